@@ hdl/rptg_pkg.sv @@
// rptg_pkg: types, codes and constants shared by the presence tracker modules
// depends on nothing; every module refers to it by scoped names
package rptg_pkg;

    localparam int GRID_SIZE = 20;
    localparam int SLOT_W    = 5;
    localparam int SLOTIDX_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // request function codes
    localparam logic [1:0] FUNC_BEACON   = 2'd0;
    localparam logic [1:0] FUNC_READINGS = 2'd1;
    localparam logic [1:0] FUNC_TICK     = 2'd2;

    // event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_NEW    = 2'd1;
    localparam logic [1:0] EV_DETECT = 2'd2;
    localparam logic [1:0] EV_ABSENT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_HOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABSENT_HOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COL       = 3'd4;

    // reset values
    localparam logic signed [7:0] NEAR_THRESHOLD_RST = -8'sd50;
    localparam logic [7:0]        DETECT_HOLD_RST    = 8'd15;
    localparam logic [7:0]        ABSENT_HOLD_RST    = 8'd30;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [7:0]  rssi;
        logic [15:0]        sender_id;
        logic [31:0]        now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           event_res;
        logic [15:0]          event_node;
        logic [31:0]          event_time;
        logic                 send_request;
        logic                 send_beacon;
        logic [SLOTIDX_W-1:0] slot_index;
    } out_item_t;

    typedef struct packed {
        logic signed [7:0]   near_threshold;
        logic [7:0]          detect_hold_seconds;
        logic [7:0]          absent_hold_seconds;
        logic [SLOT_W-1:0]   grid_row;
        logic [SLOT_W-1:0]   grid_col;
    } cfg_t;

endpackage

@@ hdl/rptg_cfg.sv @@
// rptg_cfg: configuration register file written through the config channel
// depends on rptg_pkg
module rptg_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rptg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rptg_pkg::CFG_DAT_W-1:0]    cfg_data,
    output rptg_pkg::cfg_t                    cfg
);

    rptg_pkg::cfg_t cfg_reg;
    rptg_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rptg_pkg::REG_NEAR_THRESHOLD: cfg_next.near_threshold = cfg_data;
                rptg_pkg::REG_DETECT_HOLD:    cfg_next.detect_hold_seconds = cfg_data;
                rptg_pkg::REG_ABSENT_HOLD:    cfg_next.absent_hold_seconds = cfg_data;
                rptg_pkg::REG_GRID_ROW:
                    cfg_next.grid_row = cfg_data[rptg_pkg::SLOT_W-1:0];
                rptg_pkg::REG_GRID_COL:
                    cfg_next.grid_col = cfg_data[rptg_pkg::SLOT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold      <= rptg_pkg::NEAR_THRESHOLD_RST;
            cfg_reg.detect_hold_seconds <= rptg_pkg::DETECT_HOLD_RST;
            cfg_reg.absent_hold_seconds <= rptg_pkg::ABSENT_HOLD_RST;
            cfg_reg.grid_row            <= '0;
            cfg_reg.grid_col            <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/rptg_core.sv @@
// rptg_core: neighbour presence state and slot counters with the per-request
// update logic; depends on rptg_pkg
module rptg_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  rptg_pkg::in_item_t    item,
    input  rptg_pkg::cfg_t        cfg,
    output rptg_pkg::out_item_t   result
);

    logic [15:0]               held_node_reg,   held_node_next;
    logic                      near_valid_reg,  near_valid_next;
    logic [31:0]               near_since_reg,  near_since_next;
    logic                      away_valid_reg,  away_valid_next;
    logic [31:0]               away_since_reg,  away_since_next;
    logic                      pending_reg,     pending_next;
    logic [rptg_pkg::SLOT_W-1:0] slot_row_reg,  slot_row_next;
    logic [rptg_pkg::SLOT_W-1:0] slot_col_reg,  slot_col_next;

    logic [31:0] near_elapsed;
    logic [31:0] away_elapsed;
    logic        near_detect_due;
    logic        near_absent_due;
    logic        away_absent_due;
    logic        col_wrap;
    logic        row_wrap;
    logic        away_hit;
    logic        near_hit;
    logic [9:0]  slot_full;

    assign near_elapsed    = item.now_seconds - near_since_reg;
    assign away_elapsed    = item.now_seconds - away_since_reg;
    assign near_detect_due = near_elapsed >= {24'd0, cfg.detect_hold_seconds};
    assign near_absent_due = near_elapsed >= {24'd0, cfg.absent_hold_seconds};
    assign away_absent_due = away_elapsed >= {24'd0, cfg.absent_hold_seconds};
    assign col_wrap = ({1'b0, slot_col_reg} + 6'd1) >= 6'(rptg_pkg::GRID_SIZE);
    assign row_wrap = ({1'b0, slot_row_reg} + 6'd1) >= 6'(rptg_pkg::GRID_SIZE);
    assign slot_full = 10'(slot_row_reg) * 10'(rptg_pkg::GRID_SIZE) + 10'(slot_col_reg);
    // an away expiry drops the neighbour, so the near check then sees nothing
    assign away_hit = away_valid_reg && away_absent_due;
    assign near_hit = near_valid_reg && !away_hit && near_absent_due;

    always_comb
    begin
        held_node_next  = held_node_reg;
        near_valid_next = near_valid_reg;
        near_since_next = near_since_reg;
        away_valid_next = away_valid_reg;
        away_since_next = away_since_reg;
        pending_next    = pending_reg;
        slot_row_next   = slot_row_reg;
        slot_col_next   = slot_col_reg;
        result          = '0;

        unique case (item.func)
            rptg_pkg::FUNC_BEACON:
            begin
                if (item.rssi >= cfg.near_threshold)
                begin
                    if (held_node_reg == 16'd0)
                    begin
                        held_node_next    = item.sender_id;
                        result.event_res  = rptg_pkg::EV_NEW;
                        result.event_node = item.sender_id;
                    end
                    away_valid_next = 1'b0;
                    away_since_next = '0;
                    if (!near_valid_reg)
                    begin
                        near_valid_next = 1'b1;
                        near_since_next = item.now_seconds;
                    end
                    else if (near_detect_due)
                    begin
                        // a sender adopted by this same beacon is the one reported
                        result.event_res  = rptg_pkg::EV_DETECT;
                        result.event_node = held_node_next;
                        result.event_time = near_since_reg;
                        near_since_next   = item.now_seconds;
                        pending_next      = 1'b1;
                    end
                end
                else if (held_node_reg != 16'd0)
                begin
                    near_valid_next = 1'b0;
                    near_since_next = '0;
                    if (!away_valid_reg)
                    begin
                        away_valid_next = 1'b1;
                        away_since_next = item.now_seconds;
                    end
                    else if (away_absent_due)
                    begin
                        result.event_res  = rptg_pkg::EV_ABSENT;
                        result.event_node = held_node_reg;
                        result.event_time = away_since_reg;
                        held_node_next    = '0;
                        away_valid_next   = 1'b0;
                        away_since_next   = '0;
                    end
                end
            end
            rptg_pkg::FUNC_READINGS:
            begin
                pending_next = 1'b0;
            end
            rptg_pkg::FUNC_TICK:
            begin
                if (pending_reg)
                begin
                    result.send_request = 1'b1;
                end
                else
                begin
                    result.send_beacon = (slot_row_reg == cfg.grid_row)
                                      || (slot_col_reg == cfg.grid_col);
                    result.slot_index  = slot_full[rptg_pkg::SLOTIDX_W-1:0];
                    if (col_wrap)
                    begin
                        slot_col_next = '0;
                        slot_row_next = row_wrap ? '0 : slot_row_reg + 1'b1;
                        if (away_hit || near_hit)
                        begin
                            result.event_res  = rptg_pkg::EV_ABSENT;
                            result.event_node = held_node_reg;
                            result.event_time = away_hit ? away_since_reg : near_since_reg;
                            held_node_next    = '0;
                            near_valid_next   = 1'b0;
                            near_since_next   = '0;
                            away_valid_next   = 1'b0;
                            away_since_next   = '0;
                        end
                    end
                    else
                    begin
                        slot_col_next = slot_col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_node_reg  <= '0;
            near_valid_reg <= 1'b0;
            near_since_reg <= '0;
            away_valid_reg <= 1'b0;
            away_since_reg <= '0;
            pending_reg    <= 1'b0;
            slot_row_reg   <= '0;
            slot_col_reg   <= '0;
        end
        else if (fire)
        begin
            held_node_reg  <= held_node_next;
            near_valid_reg <= near_valid_next;
            near_since_reg <= near_since_next;
            away_valid_reg <= away_valid_next;
            away_since_reg <= away_since_next;
            pending_reg    <= pending_next;
            slot_row_reg   <= slot_row_next;
            slot_col_reg   <= slot_col_next;
        end
    end

endmodule

@@ hdl/rssi_presence_tracker_with_grid_slots_unit.sv @@
// rssi presence tracker with quorum grid slots: top level
// a request waits in the input register; its result is held in the output register
// throughput: one request per cycle while out_stall is low
// an output register lets a new request enter while a result waits to be taken
// reset (rst_n low, asynchronous): no neighbour held, timers and counters zero,
// configuration at its defaults; depends on rptg_pkg, rptg_cfg, rptg_core
module rssi_presence_tracker_with_grid_slots_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rptg_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rptg_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rptg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rptg_pkg::CFG_DAT_W-1:0]    cfg_data
);

    rptg_pkg::cfg_t       cfg;
    rptg_pkg::out_item_t  result;

    logic                 in_valid_reg;
    rptg_pkg::in_item_t   in_data_reg;
    logic                 out_valid_reg;
    rptg_pkg::out_item_t  out_data_reg;
    logic                 advance;

    // the held request moves on when the result register is free or drains
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    rptg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rptg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule
